@@ rtl/core/lpb_pkg.sv @@
// Shared types, register layouts and decode codes for the LED PWM register bank.
// Used by lpb_ctrl, lpb_datapath and led_pwm_register_bank_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpb_pkg;

	// Default channel capacity of the bank.
	localparam int MAX_CHANNELS_DEF = 36;

	// Chip layout selections.
	localparam logic [1:0] VAR_36CH = 2'd0;
	localparam logic [1:0] VAR_28CH = 2'd1;
	localparam logic [1:0] VAR_18CH = 2'd2;
	localparam logic [1:0] VAR_16CH = 2'd3;

	// Decoded register kinds.
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_SSD  = 3'd1;
	localparam logic [2:0] KIND_UPD  = 3'd2;
	localparam logic [2:0] KIND_RST  = 3'd3;
	localparam logic [2:0] KIND_GLB  = 3'd4;
	localparam logic [2:0] KIND_PWM  = 3'd5;
	localparam logic [2:0] KIND_CTL  = 3'd6;

	// Register addresses used by the layouts.
	localparam logic [7:0] ADDR_SHUTDOWN = 8'h00;
	localparam logic [7:0] ADDR_UPD_WIDE = 8'h25;
	localparam logic [7:0] ADDR_GLB_WIDE = 8'h4a;
	localparam logic [7:0] ADDR_RST_WIDE = 8'h4f;
	localparam logic [7:0] ADDR_UPD_18CH = 8'h16;
	localparam logic [7:0] ADDR_RST_18CH = 8'h17;
	localparam logic [7:0] ADDR_UPD_16CH = 8'hb0;

	// One chip layout.
	typedef struct packed {
		logic [7:0] n;
		logic [7:0] pwm_base;
		logic       reversed;
		logic [7:0] ctl_base;
		logic [7:0] ctl_regs;
		logic [7:0] upd;
		logic       has_rst;
		logic [7:0] rst;
		logic       has_glb;
		logic [7:0] glb;
		logic       ssd_bit7;
	} layout_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic copy_rd;
		logic probe_rd;
		logic result_load;
	} lpb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_update;
		logic copy_last;
	} lpb_status_t;

	// Layout table lookup.
	function automatic layout_t layout_of(input logic [1:0] variant);
		layout_t l;
		case (variant)
			VAR_36CH: l = '{8'd36, 8'h01, 1'b0, 8'h26, 8'd36, ADDR_UPD_WIDE,
				1'b1, ADDR_RST_WIDE, 1'b1, ADDR_GLB_WIDE, 1'b0};
			VAR_28CH: l = '{8'd28, 8'h05, 1'b0, 8'h2a, 8'd28, ADDR_UPD_WIDE,
				1'b1, ADDR_RST_WIDE, 1'b1, ADDR_GLB_WIDE, 1'b0};
			VAR_18CH: l = '{8'd18, 8'h01, 1'b0, 8'h13, 8'd3, ADDR_UPD_18CH,
				1'b1, ADDR_RST_18CH, 1'b0, 8'h00, 1'b0};
			default: l = '{8'd16, 8'h10, 1'b1, 8'h01, 8'd2, ADDR_UPD_16CH,
				1'b0, 8'h00, 1'b0, 8'h00, 1'b1};
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lpb_ctrl.sv @@
// Controller state machine of the LED PWM register bank.
// Sequences load, execute, copy sweep, probe read and result; uses lpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpb_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  lpb_pkg::lpb_status_t st,
	output lpb_pkg::lpb_cmd_t   cmd
);
	import lpb_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_COPY   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_PROBE  = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	// The output register can take a new result when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = st.is_update ? S_COPY : S_PROBE;
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				if (st.copy_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe_rd = 1'b1;
				state_nxt    = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.result_load = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lpb_datapath.sv @@
// Datapath of the LED PWM register bank: address decode, shadow and active
// duty memories, enable bits, control flags and result register; uses lpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpb_datapath #(
	parameter int MAX_CHANNELS = lpb_pkg::MAX_CHANNELS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lpb_pkg::lpb_cmd_t    cmd,
	output lpb_pkg::lpb_status_t st,
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_data,
	input  wire  [7:0]           reg_address,
	input  wire  [7:0]           write_data,
	input  wire  [5:0]           probe_channel,
	output logic                 address_hit,
	output logic [7:0]           probe_duty,
	output logic                 probe_enabled,
	output logic                 in_shutdown
);
	import lpb_pkg::*;

	localparam int         IDX_W = $clog2(MAX_CHANNELS);
	localparam logic [7:0] MAX8  = 8'(MAX_CHANNELS);

	// Configuration and latched request.
	logic [1:0] variant_q;
	logic [7:0] addr_q;
	logic [7:0] data_q;
	logic [5:0] probe_q;

	// Bank state.
	logic [7:0]              sh_mem  [MAX_CHANNELS];
	logic [7:0]              act_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] sh_vld_q;
	logic [MAX_CHANNELS-1:0] act_vld_q;
	logic [MAX_CHANNELS-1:0] en_q;
	logic                    sd_q;
	logic                    go_q;

	// Copy sweep.
	logic [IDX_W-1:0] cpy_cnt_q;
	logic             cpy_s1;
	logic [IDX_W-1:0] cpy_idx_s1;
	logic             cpy_vld_s1;
	logic [7:0]       sh_rd_s1;

	// Probe and result.
	logic       hit_q;
	logic       prb_en_q;
	logic       act_rdv_q;
	logic [7:0] act_rd_q;
	logic       out_hit_q;
	logic [7:0] out_duty_q;
	logic       out_en_q;
	logic       out_sd_q;

	// Decode signals.
	layout_t                 lay;
	logic [7:0]              pwm_off;
	logic [7:0]              pwm_ch0;
	logic                    pwm_in;
	logic [7:0]              ctl_off;
	logic                    ctl_in;
	logic [2:0]              kind;
	logic [IDX_W-1:0]        pwm_idx;
	logic [MAX_CHANNELS-1:0] en_sel;
	logic [MAX_CHANNELS-1:0] en_bit;
	logic [7:0]              lim8;
	logic                    probe_ok;
	logic [IDX_W-1:0]        pidx;
	logic                    exec_rst;

	// Address decode under the selected layout.
	assign lay     = layout_of(variant_q);
	assign pwm_off = addr_q - lay.pwm_base;
	assign pwm_in  = (addr_q >= lay.pwm_base) && (pwm_off < lay.n);
	assign pwm_ch0 = lay.reversed ? (lay.n - 8'd1 - pwm_off) : pwm_off;
	assign pwm_idx = pwm_ch0[IDX_W-1:0];
	assign ctl_off = addr_q - lay.ctl_base;
	assign ctl_in  = (addr_q >= lay.ctl_base) && (ctl_off < lay.ctl_regs);

	always_comb begin
		if (addr_q == ADDR_SHUTDOWN) begin
			kind = KIND_SSD;
		end else if (addr_q == lay.upd) begin
			kind = KIND_UPD;
		end else if (lay.has_rst && addr_q == lay.rst) begin
			kind = KIND_RST;
		end else if (lay.has_glb && addr_q == lay.glb) begin
			kind = KIND_GLB;
		end else if (pwm_in) begin
			kind = (pwm_ch0 < MAX8) ? KIND_PWM : KIND_NONE;
		end else if (ctl_in) begin
			kind = KIND_CTL;
		end else begin
			kind = KIND_NONE;
		end
	end

	assign exec_rst = cmd.exec && (kind == KIND_RST);

	// Per-channel enable selection from an enable-register write.
	for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_en
		localparam int   GRP6 = j / 6;
		localparam int   POS6 = j % 6;
		localparam int   POS8 = j % 8;
		localparam int   REG8 = (j < 8) ? 1 : 0;
		localparam logic IN16 = (j < 16);
		always_comb begin
			case (variant_q)
				VAR_18CH: begin
					en_sel[j] = (ctl_off == 8'(GRP6));
					en_bit[j] = data_q[POS6];
				end
				VAR_16CH: begin
					en_sel[j] = IN16 && (ctl_off == 8'(REG8));
					en_bit[j] = data_q[POS8];
				end
				default: begin
					en_sel[j] = (ctl_off == 8'(j));
					en_bit[j] = data_q[0];
				end
			endcase
		end
	end

	// Probe range check against the layout's channel count.
	assign lim8     = (lay.n < MAX8) ? lay.n : MAX8;
	assign probe_ok = (probe_q != 6'd0) && ({2'b00, probe_q} <= lim8);
	assign pidx     = probe_ok ? IDX_W'(probe_q - 6'd1) : '0;

	// Status toward the controller.
	assign st.is_update = (kind == KIND_UPD);
	assign st.copy_last = (cpy_cnt_q == IDX_W'(MAX_CHANNELS - 1));

	// Configuration register and request latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_36CH;
		end else if (cfg_we) begin
			variant_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= reg_address;
			data_q  <= write_data;
			probe_q <= probe_channel;
		end
	end

	// Control flags, enables and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q      <= 1'b1;
			go_q      <= 1'b0;
			en_q      <= '0;
			sh_vld_q  <= '0;
			act_vld_q <= '0;
			cpy_cnt_q <= '0;
			cpy_s1    <= 1'b0;
		end else begin
			cpy_s1 <= cmd.copy_rd;
			if (exec_rst) begin
				sd_q      <= 1'b1;
				go_q      <= 1'b0;
				en_q      <= '0;
				sh_vld_q  <= '0;
				act_vld_q <= '0;
			end else if (cmd.exec) begin
				case (kind)
					KIND_SSD: sd_q <= lay.ssd_bit7 ? data_q[7] : ~data_q[0];
					KIND_GLB: go_q <= data_q[0];
					KIND_PWM: sh_vld_q[pwm_idx] <= 1'b1;
					KIND_CTL: en_q <= (en_q & ~en_sel) | (en_bit & en_sel);
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				cpy_cnt_q <= '0;
			end else if (cmd.copy_rd) begin
				cpy_cnt_q <= cpy_cnt_q + 1'b1;
			end
			if (cpy_s1) begin
				act_vld_q[cpy_idx_s1] <= cpy_vld_s1;
			end
		end
	end

	// Shadow duty memory: written by PWM requests, read by the copy sweep.
	always_ff @(posedge clk) begin
		if (cmd.exec && kind == KIND_PWM) begin
			sh_mem[pwm_idx] <= data_q;
		end
		if (cmd.copy_rd) begin
			sh_rd_s1   <= sh_mem[cpy_cnt_q];
			cpy_idx_s1 <= cpy_cnt_q;
			cpy_vld_s1 <= sh_vld_q[cpy_cnt_q];
		end
	end

	// Active duty memory: written by the copy sweep, read by the probe.
	always_ff @(posedge clk) begin
		if (cpy_s1) begin
			act_mem[cpy_idx_s1] <= sh_rd_s1;
		end
		if (cmd.probe_rd) begin
			act_rd_q  <= act_mem[pidx];
			act_rdv_q <= act_vld_q[pidx];
			prb_en_q  <= probe_ok && en_q[pidx];
		end
	end

	// Decode result and output register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hit_q <= (kind != KIND_NONE);
		end
		if (cmd.result_load) begin
			out_hit_q  <= hit_q;
			out_en_q   <= prb_en_q;
			out_sd_q   <= sd_q;
			out_duty_q <= (prb_en_q && !sd_q && !go_q && act_rdv_q) ? act_rd_q : 8'd0;
		end
	end

	assign address_hit   = out_hit_q;
	assign probe_duty    = out_duty_q;
	assign probe_enabled = out_en_q;
	assign in_shutdown   = out_sd_q;

endmodule

`default_nettype wire

@@ rtl/core/led_pwm_register_bank_core.sv @@
// Top level of the LED PWM register bank: controller plus datapath.
// Depends on lpb_pkg, lpb_ctrl and lpb_datapath.
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_data (chip layout select)
//   in       in_valid/in_ready    reg_address, write_data, probe_channel
//   out      out_valid/out_ready  address_hit, probe_duty, probe_enabled, in_shutdown
//
// A request runs the execute, probe and result states between acceptances; a
// write to the update register adds the copy sweep and a drain state, the sweep
// using the shadow memory's single read port, one channel per cycle.
// Reset sets shutdown and clears other flags, enables and valid bits at once; no clearing pass.
// The output register holds a result while out_ready is low; the next request
// is accepted meanwhile and waits in its result state only if the register is full.
`timescale 1ns / 1ps
`default_nettype none

module led_pwm_register_bank_core #(
	parameter int MAX_CHANNELS = lpb_pkg::MAX_CHANNELS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] cfg_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] reg_address,
	input  wire  [7:0] write_data,
	input  wire  [5:0] probe_channel,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       address_hit,
	output logic [7:0] probe_duty,
	output logic       probe_enabled,
	output logic       in_shutdown
);
	import lpb_pkg::*;

	lpb_cmd_t    cmd;
	lpb_status_t st;

	// Configuration writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	lpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	lpb_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.reg_address   (reg_address),
		.write_data    (write_data),
		.probe_channel (probe_channel),
		.address_hit   (address_hit),
		.probe_duty    (probe_duty),
		.probe_enabled (probe_enabled),
		.in_shutdown   (in_shutdown)
	);

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// At most one datapath command per cycle.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");

	// A loaded result is presented on the next cycle.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> out_valid)
		else $error("result loaded but not presented");

	// The copy sweep stops after its last channel.
	a_copy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_rd && st.copy_last) |=> !cmd.copy_rd)
		else $error("copy sweep ran past its last channel");

endmodule

`default_nettype wire
